// File: rtl/core/sphb_pkg.sv
// Shared types and constants for the sequenced power history buffer.
package sphb_pkg;

    localparam int DEF_HISTORY_DEPTH = 128;
    localparam int DEF_TIME_WIDTH    = 48;
    localparam int DEF_LAST_ID       = 255;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 120;
    localparam int APB_ADDR_W = 3;

    localparam logic [7:0] GOOD_LENGTH       = 8'd5;
    localparam logic [7:0] LIMIT_RESET       = 8'd128;
    localparam logic       REG_RECORD_LIMIT  = 1'b0;
    localparam logic       ACTION_ADD        = 1'b0;
    localparam logic       ACTION_READ       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    typedef struct packed {
        logic do_add;
        logic do_read;
        logic out_read;
    } sphb_cmd_t;

endpackage

// File: rtl/core/sphb_ctrl.sv
// Controller state machine: handshakes and datapath commands.
module sphb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_action,
    input  logic               out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output sphb_pkg::sphb_cmd_t cmd
);

    sphb_pkg::state_t state_reg;
    sphb_pkg::state_t state_next;
    logic             take;

    assign in_ready  = (state_reg == sphb_pkg::ST_IDLE) ||
                       ((state_reg == sphb_pkg::ST_OUT) && out_ready);
    assign out_valid = (state_reg == sphb_pkg::ST_OUT);
    assign take      = in_valid && in_ready;

    assign cmd.do_add   = take && (in_action == sphb_pkg::ACTION_ADD);
    assign cmd.do_read  = take && (in_action == sphb_pkg::ACTION_READ);
    assign cmd.out_read = (state_reg == sphb_pkg::ST_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sphb_pkg::ST_IDLE,
            sphb_pkg::ST_OUT:
            begin
                if (take)
                begin
                    state_next = (in_action == sphb_pkg::ACTION_READ) ? sphb_pkg::ST_READ
                                                                      : sphb_pkg::ST_OUT;
                end
                else if (state_reg == sphb_pkg::ST_OUT && out_ready)
                begin
                    state_next = sphb_pkg::ST_IDLE;
                end
            end
            sphb_pkg::ST_READ:
            begin
                state_next = sphb_pkg::ST_OUT;
            end
            default:
            begin
                state_next = sphb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sphb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/sphb_datapath.sv
// Datapath: history ring memory, pointer and count, LINEAR11 decode, result register.
module sphb_datapath #(
    parameter int HISTORY_DEPTH = sphb_pkg::DEF_HISTORY_DEPTH,
    parameter int TIME_WIDTH    = sphb_pkg::DEF_TIME_WIDTH,
    parameter int LAST_ID       = sphb_pkg::DEF_LAST_ID
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sphb_pkg::sphb_cmd_t               cmd,
    input  logic [sphb_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [7:0]                        record_limit,
    output logic [sphb_pkg::OUT_DATA_W-1:0]   out_data
);

    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = ((CW > 8) ? CW : 8) + 1;
    localparam int AW = ((PW > 7) ? PW : 7) + 1;

    function automatic logic signed [25:0] decode_linear(input logic [15:0] w);
        logic [4:0]          e_bits;
        logic [10:0]         m_bits;
        logic [10:0]         mag;
        logic [4:0]          k;
        logic signed [25:0]  m_ext;
        logic signed [25:0]  r;
        e_bits = w[15:11];
        m_bits = w[10:0];
        m_ext  = 26'(signed'(m_bits));
        if (!e_bits[4])
        begin
            r = m_ext <<< e_bits[3:0];
        end
        else
        begin
            k   = 5'(~e_bits + 5'd1);
            mag = m_bits[10] ? 11'(~m_bits + 11'd1) : m_bits;
            mag = mag >> k;
            r   = m_bits[10] ? -signed'({15'd0, mag}) : signed'({15'd0, mag});
        end
        return r;
    endfunction

    logic [7:0]            id_store      [HISTORY_DEPTH];
    logic [TIME_WIDTH-1:0] time_store    [HISTORY_DEPTH];
    logic signed [25:0]    average_store [HISTORY_DEPTH];
    logic signed [25:0]    maximum_store [HISTORY_DEPTH];

    logic [PW-1:0]         newest_ptr_reg;
    logic [CW-1:0]         held_count_reg;
    logic [7:0]            newest_id_reg;

    logic                  rd_valid_reg;
    logic [7:0]            rd_id_reg;
    logic [TIME_WIDTH-1:0] rd_time_reg;
    logic signed [25:0]    rd_avg_reg;
    logic signed [25:0]    rd_max_reg;
    logic [sphb_pkg::OUT_DATA_W-1:0] result_reg;

    logic [7:0]            in_len;
    logic [7:0]            in_id;
    logic [15:0]           in_avg;
    logic [15:0]           in_max;
    logic [47:0]           in_time;
    logic [6:0]            in_idx;

    logic                  is_dup;
    logic                  in_order;
    logic [CW-1:0]         eff_count;
    logic                  do_store;
    logic                  add_ok;
    logic [PW-1:0]         slot;
    logic [LW-1:0]         lim;
    logic [LW-1:0]         inc_count;
    logic [CW-1:0]         count_next;
    logic [63:0]           time_pad;
    logic signed [25:0]    avg_dec;
    logic signed [25:0]    max_dec;

    logic                  rd_hit;
    logic [AW-1:0]         rd_diff;
    logic [PW-1:0]         rd_addr;

    logic [63:0]           cnt_pad;
    logic [63:0]           rtime_pad;

    assign in_len  = in_data[7:0];
    assign in_id   = in_data[15:8];
    assign in_avg  = in_data[31:16];
    assign in_max  = in_data[47:32];
    assign in_time = in_data[95:48];
    assign in_idx  = in_data[102:96];

    assign in_order = (({1'b0, newest_id_reg} + 9'd1) == {1'b0, in_id}) ||
                      ((newest_id_reg == 8'(LAST_ID)) && (in_id == 8'd0));
    assign is_dup   = (held_count_reg != '0) && (newest_id_reg == in_id);

    // out-of-order ID restarts the history before the store
    assign eff_count = (held_count_reg != '0 && !in_order) ? '0 : held_count_reg;

    always_comb
    begin
        do_store   = 1'b0;
        add_ok     = 1'b0;
        count_next = held_count_reg;
        if (in_len == 8'd0)
        begin
            add_ok     = 1'b1;
            count_next = '0;
        end
        else if (in_len == sphb_pkg::GOOD_LENGTH && !is_dup)
        begin
            do_store   = 1'b1;
            add_ok     = 1'b1;
            count_next = (inc_count > lim) ? eff_count : inc_count[CW-1:0];
        end
    end

    assign lim       = (LW'(record_limit) > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH)
                                                                : LW'(record_limit);
    assign inc_count = LW'(eff_count) + LW'(1);
    assign slot      = (eff_count == '0) ? newest_ptr_reg :
                       (newest_ptr_reg == PW'(HISTORY_DEPTH - 1)) ? '0 :
                       PW'(newest_ptr_reg + PW'(1));
    assign time_pad  = 64'(in_time);
    assign avg_dec   = decode_linear(in_avg);
    assign max_dec   = decode_linear(in_max);

    assign rd_hit  = (LW'(in_idx) < LW'(held_count_reg));
    assign rd_diff = (AW'(newest_ptr_reg) >= AW'(in_idx))
                     ? AW'(newest_ptr_reg) - AW'(in_idx)
                     : AW'(newest_ptr_reg) + AW'(HISTORY_DEPTH) - AW'(in_idx);
    assign rd_addr = rd_diff[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.do_add && do_store)
        begin
            id_store[slot]      <= in_id;
            time_store[slot]    <= time_pad[TIME_WIDTH-1:0];
            average_store[slot] <= avg_dec;
            maximum_store[slot] <= max_dec;
        end
        if (cmd.do_read)
        begin
            rd_id_reg   <= id_store[rd_addr];
            rd_time_reg <= time_store[rd_addr];
            rd_avg_reg  <= average_store[rd_addr];
            rd_max_reg  <= maximum_store[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_ptr_reg <= '0;
            held_count_reg <= '0;
            newest_id_reg  <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.do_add)
            begin
                held_count_reg <= count_next;
                if (do_store)
                begin
                    newest_ptr_reg <= slot;
                    newest_id_reg  <= in_id;
                end
            end
            if (cmd.do_read)
            begin
                rd_valid_reg <= rd_hit;
            end
        end
    end

    assign cnt_pad   = 64'(cmd.do_add ? count_next : held_count_reg);
    assign rtime_pad = 64'(rd_time_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.do_add)
        begin
            result_reg <= {2'b00, cnt_pad[7:0], 108'd0, 1'b0, add_ok};
        end
        else if (cmd.out_read)
        begin
            if (rd_valid_reg)
            begin
                result_reg <= {2'b00, cnt_pad[7:0], rd_max_reg, rd_avg_reg,
                               rtime_pad[47:0], rd_id_reg, 1'b1, 1'b0};
            end
            else
            begin
                result_reg <= {2'b00, cnt_pad[7:0], 110'd0};
            end
        end
    end

    assign out_data = result_reg;

endmodule

// File: rtl/core/sequenced_power_history_buffer.sv
// Top level of the sequenced power history buffer: config register, controller, datapath.
//
//  channel   | direction | handshake             | payload
//  s_axis    | in        | tvalid/tready         | tdata: add or read request, tuser: action
//  m_axis    | out       | tvalid/tready         | tdata: one result item per request
//  apb       | in        | psel/penable, pready  | record_limit at byte address 0
//
// An add's result is registered directly; a read also passes the registered ring memory
// read. A new item is taken in the cycle its predecessor's result is taken, so adds
// sustain 1 item per cycle while m_axis is not stalled; a read holds off new items
// during its memory read. Reset clears pointer, count, newest ID, read flag and state,
// sets record_limit to 128, leaves ring memory; a stalled result holds m_axis_tdata.
module sequenced_power_history_buffer #(
    parameter int HISTORY_DEPTH = sphb_pkg::DEF_HISTORY_DEPTH,
    parameter int TIME_WIDTH    = sphb_pkg::DEF_TIME_WIDTH,
    parameter int LAST_ID       = sphb_pkg::DEF_LAST_ID
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // record_length[7:0], seq_id[15:8], avg_raw[31:16], max_raw[47:32],
    // timestamp_ms[95:48], read_index[102:96], zero[103]
    input  logic [sphb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accepted[0], entry_valid[1], entry_id[9:2], entry_time[57:10],
    // entry_average[83:58], entry_maximum[109:84], entry_count[117:110], zero[119:118]
    output logic [sphb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sphb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [7:0]          record_limit_reg;
    sphb_pkg::sphb_cmd_t cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sphb_pkg::REG_RECORD_LIMIT) ? {24'd0, record_limit_reg}
                                                             : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_limit_reg <= sphb_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == sphb_pkg::REG_RECORD_LIMIT)
        begin
            record_limit_reg <= pwdata[7:0];
        end
    end

    sphb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser[0]),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    sphb_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH),
        .LAST_ID       (LAST_ID)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_data      (s_axis_tdata),
        .record_limit (record_limit_reg),
        .out_data     (m_axis_tdata)
    );

endmodule

// File: rtl/core/sphb_checker.sv
// Port-level checker for the sequenced power history buffer, with its bind.
module sphb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sphb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sphb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic take_add;
    logic take_read;

    assign take_add  = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser[0] == sphb_pkg::ACTION_ADD);
    assign take_read = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser[0] == sphb_pkg::ACTION_READ);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_add |=> m_axis_tvalid && !m_axis_tdata[1])
        else $error("add item result missing or marked as entry");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_add && s_axis_tdata[7:0] == 8'd0 |=>
            m_axis_tdata[0] && m_axis_tdata[117:110] == 8'd0)
        else $error("clear not accepted or count not zero");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take_read |=> !m_axis_tvalid ##1 m_axis_tvalid && !m_axis_tdata[0])
        else $error("read result timing or accepted flag wrong");

endmodule

bind sequenced_power_history_buffer sphb_checker u_sphb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
